FILE: design/lc3_instruction_execute_unit_macros.svh
// Assertion macros used by the checker file of the execute unit.
`ifndef LC3_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define LC3_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LC3_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lc3 execute unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define LC3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lc3 execute unit check failed");

`endif

FILE: design/lc3_pkg.sv
// Shared types and constants of the LC-3 instruction execute unit.
package lc3_pkg;

    localparam int ADDR_BITS_DEF = 16;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_SETPC = 2'd1;
    localparam logic [1:0] KIND_EXEC  = 2'd2;

    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_RTI  = 4'h8;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'ha;
    localparam logic [3:0] OP_STI  = 4'hb;
    localparam logic [3:0] OP_JMP  = 4'hc;
    localparam logic [3:0] OP_RES  = 4'hd;
    localparam logic [3:0] OP_LEA  = 4'he;
    localparam logic [3:0] OP_TRAP = 4'hf;

    localparam logic [15:0] KBSR_ADDR = 16'hfe00;
    localparam logic [15:0] KBDR_ADDR = 16'hfe02;
    localparam logic [15:0] DSR_ADDR  = 16'hfe04;
    localparam logic [15:0] DDR_ADDR  = 16'hfe06;
    localparam logic [15:0] MCR_ADDR  = 16'hfffe;

    localparam logic [15:0] STATUS_READY = 16'h8000;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_ILLEGAL = 2'd1;
    localparam logic [1:0] FAULT_PRIV    = 2'd2;

    localparam logic [2:0] CC_N = 3'b100;
    localparam logic [2:0] CC_Z = 3'b010;
    localparam logic [2:0] CC_P = 3'b001;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [15:0] data_word;
        logic [7:0]  key_char;
    } req_t;

    typedef struct packed {
        logic        char_valid;
        logic [7:0]  out_char;
        logic        running;
        logic [1:0]  fault;
        logic        key_used;
        logic [15:0] pc_now;
    } rsp_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic item_load;
        logic host_wr;
        logic pc_set;
        logic fetch;
        logic ir_load;
        logic exec;
        logic ptr_rd;
        logic ptr_st;
        logic wb_bus;
        logic trap_pc;
        logic out_load;
    } ctl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] op;
        logic       run;
    } stat_t;

endpackage

FILE: design/lc3_controller.sv
// Sequencer that steps each item through dispatch and, for instructions, fetch, execute, memory and trap phases.
module lc3_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  lc3_pkg::stat_t stat,
    output lc3_pkg::ctl_t  ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_IR   = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_MEM1 = 3'd4;
    localparam logic [2:0] S_MEM2 = 3'd5;
    localparam logic [2:0] S_TRAP = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.item_load = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_DONE;
                case (stat.kind)
                    lc3_pkg::KIND_WRITE: ctl.host_wr = 1'b1;
                    lc3_pkg::KIND_SETPC: ctl.pc_set = 1'b1;
                    lc3_pkg::KIND_EXEC:
                    begin
                        if (stat.run)
                        begin
                            ctl.fetch  = 1'b1;
                            state_next = S_IR;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_IR:
            begin
                ctl.ir_load = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                case (stat.op) inside
                    lc3_pkg::OP_LD, lc3_pkg::OP_LDR,
                    lc3_pkg::OP_LDI, lc3_pkg::OP_STI: state_next = S_MEM1;
                    lc3_pkg::OP_TRAP:                 state_next = S_TRAP;
                    default:                          state_next = S_DONE;
                endcase
            end
            S_MEM1:
            begin
                case (stat.op)
                    lc3_pkg::OP_LDI:
                    begin
                        ctl.ptr_rd = 1'b1;
                        state_next = S_MEM2;
                    end
                    lc3_pkg::OP_STI:
                    begin
                        ctl.ptr_st = 1'b1;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        ctl.wb_bus = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_MEM2:
            begin
                ctl.wb_bus = 1'b1;
                state_next = S_DONE;
            end
            S_TRAP:
            begin
                ctl.trap_pc = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: design/lc3_datapath.sv
// Register file, word memory, device registers and result register of the core.
module lc3_datapath #(
    parameter int ADDR_BITS = lc3_pkg::ADDR_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lc3_pkg::req_t  req,
    input  lc3_pkg::ctl_t  ctl,
    output lc3_pkg::stat_t stat,
    output lc3_pkg::rsp_t  rsp
);

    localparam int MEM_WORDS = 1 << ADDR_BITS;

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] mem_q;

    lc3_pkg::req_t item_reg;
    lc3_pkg::rsp_t rsp_reg;
    logic [15:0] ir_reg;
    logic [15:0] a_reg;
    logic [15:0] b_reg;
    logic [15:0] pc_reg;
    logic [15:0] pc_next;
    logic [2:0]  cc_reg;
    logic [15:0] gr_reg [8];
    logic [15:0] mcr_reg;
    logic [15:0] kbsr_reg;
    logic [15:0] dsr_reg;
    logic [1:0]  fault_reg;
    logic        key_hit_reg;
    logic        char_hit_reg;
    logic [7:0]  char_byte_reg;
    logic        rd_dev_reg;
    logic [15:0] rd_dev_val_reg;

    logic [15:0] bus_data;
    logic [3:0]  op;
    logic [2:0]  dr;
    logic [15:0] off9;
    logic [15:0] off6;
    logic [15:0] off11;
    logic [15:0] opnd_b;
    logic [15:0] ea;
    logic [15:0] alu;
    logic        is_alu;

    logic        rd_en;
    logic        rd_raw;
    logic [15:0] rd_addr;
    logic        st_en;
    logic        st_core;
    logic [15:0] st_addr;
    logic [15:0] st_data;
    logic        st_dev;
    logic        rd_dev;

    logic        wr_en;
    logic [2:0]  wr_idx;
    logic [15:0] wr_val;
    logic        wr_cc;
    logic [3:0]  fetch_op;
    logic        fetch_store;

    assign bus_data = rd_dev_reg ? rd_dev_val_reg : mem_q;
    assign op       = ir_reg[15:12];
    assign dr       = ir_reg[11:9];
    assign off9     = {{7{ir_reg[8]}}, ir_reg[8:0]};
    assign off6     = {{10{ir_reg[5]}}, ir_reg[5:0]};
    assign off11    = {{5{ir_reg[10]}}, ir_reg[10:0]};
    assign opnd_b   = ir_reg[5] ? {{11{ir_reg[4]}}, ir_reg[4:0]} : b_reg;
    assign ea       = (op == lc3_pkg::OP_LDR || op == lc3_pkg::OP_STR) ? a_reg + off6
                                                                       : pc_reg + off9;

    always_comb
    begin
        alu    = ea;
        is_alu = 1'b1;
        case (op)
            lc3_pkg::OP_ADD: alu = a_reg + opnd_b;
            lc3_pkg::OP_AND: alu = a_reg & opnd_b;
            lc3_pkg::OP_NOT: alu = ~a_reg;
            lc3_pkg::OP_LEA: alu = ea;
            default:         is_alu = 1'b0;
        endcase
    end

    // Read port: fetch, effective address, pointer and trap vector reads.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_raw  = 1'b0;
        rd_addr = pc_reg;
        if (ctl.fetch)
            rd_en = 1'b1;
        if (ctl.exec)
        begin
            case (op) inside
                lc3_pkg::OP_LD, lc3_pkg::OP_LDR, lc3_pkg::OP_LDI, lc3_pkg::OP_STI:
                begin
                    rd_en   = 1'b1;
                    rd_addr = ea;
                end
                lc3_pkg::OP_TRAP:
                begin
                    rd_en   = 1'b1;
                    rd_raw  = 1'b1;
                    rd_addr = {8'h00, ir_reg[7:0]};
                end
                default: rd_en = 1'b0;
            endcase
        end
        if (ctl.ptr_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = bus_data;
        end
    end

    assign rd_dev = !rd_raw && (rd_addr == lc3_pkg::KBSR_ADDR || rd_addr == lc3_pkg::KBDR_ADDR
                    || rd_addr == lc3_pkg::DSR_ADDR || rd_addr == lc3_pkg::MCR_ADDR);

    // Write port: host loads, ST/STR and the indirect store of STI.
    always_comb
    begin
        st_en   = 1'b0;
        st_core = 1'b1;
        st_addr = ea;
        st_data = b_reg;
        if (ctl.host_wr)
        begin
            st_en   = 1'b1;
            st_core = 1'b0;
            st_addr = item_reg.address;
            st_data = item_reg.data_word;
        end
        if (ctl.exec && (op == lc3_pkg::OP_ST || op == lc3_pkg::OP_STR))
            st_en = 1'b1;
        if (ctl.ptr_st)
        begin
            st_en   = 1'b1;
            st_addr = bus_data;
        end
    end

    assign st_dev = (st_addr == lc3_pkg::KBSR_ADDR || st_addr == lc3_pkg::KBDR_ADDR
                    || st_addr == lc3_pkg::DSR_ADDR || st_addr == lc3_pkg::MCR_ADDR);

    // Register file write port and condition codes.
    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = dr;
        wr_val = alu;
        wr_cc  = 1'b0;
        if (ctl.exec && is_alu)
        begin
            wr_en = 1'b1;
            wr_cc = 1'b1;
        end
        if (ctl.exec && (op == lc3_pkg::OP_JSR || op == lc3_pkg::OP_TRAP))
        begin
            wr_en  = 1'b1;
            wr_idx = 3'd7;
            wr_val = pc_reg;
        end
        if (ctl.wb_bus)
        begin
            wr_en  = 1'b1;
            wr_val = bus_data;
            wr_cc  = 1'b1;
        end
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (ctl.pc_set)
            pc_next = item_reg.data_word;
        if (ctl.ir_load)
            pc_next = pc_reg + 16'd1;
        if (ctl.trap_pc)
            pc_next = bus_data;
        if (ctl.exec)
        begin
            case (op)
                lc3_pkg::OP_BR:
                begin
                    if ((cc_reg & dr) != 3'b000)
                        pc_next = pc_reg + off9;
                end
                lc3_pkg::OP_JMP: pc_next = a_reg;
                lc3_pkg::OP_JSR: pc_next = ir_reg[11] ? pc_reg + off11 : a_reg;
                default:         pc_next = pc_reg;
            endcase
        end
    end

    // The second operand port reads the source of a store, otherwise SR2.
    assign fetch_op    = bus_data[15:12];
    assign fetch_store = (fetch_op == lc3_pkg::OP_ST || fetch_op == lc3_pkg::OP_STI
                         || fetch_op == lc3_pkg::OP_STR);

    always_ff @(posedge clk)
    begin
        if (st_en && !st_dev)
            mem[st_addr[ADDR_BITS-1:0]] <= st_data;
        if (rd_en)
            mem_q <= mem[rd_addr[ADDR_BITS-1:0]];
        if (ctl.item_load)
            item_reg <= req;
        if (ctl.ir_load)
        begin
            ir_reg <= bus_data;
            a_reg  <= gr_reg[bus_data[8:6]];
            b_reg  <= gr_reg[fetch_store ? bus_data[11:9] : bus_data[2:0]];
        end
        if (ctl.out_load)
            rsp_reg <= '{char_valid: char_hit_reg, out_char: char_byte_reg,
                         running: (mcr_reg != 16'h0000) && (fault_reg == lc3_pkg::FAULT_NONE),
                         fault: fault_reg, key_used: key_hit_reg, pc_now: pc_reg};
        if (rd_en)
        begin
            case (rd_addr)
                lc3_pkg::KBSR_ADDR: rd_dev_val_reg <= kbsr_reg;
                lc3_pkg::KBDR_ADDR: rd_dev_val_reg <= {8'h00, item_reg.key_char};
                lc3_pkg::DSR_ADDR:  rd_dev_val_reg <= dsr_reg;
                default:            rd_dev_val_reg <= mcr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            cc_reg        <= '0;
            gr_reg        <= '{default: '0};
            mcr_reg       <= lc3_pkg::STATUS_READY;
            kbsr_reg      <= lc3_pkg::STATUS_READY;
            dsr_reg       <= lc3_pkg::STATUS_READY;
            fault_reg     <= lc3_pkg::FAULT_NONE;
            key_hit_reg   <= 1'b0;
            char_hit_reg  <= 1'b0;
            char_byte_reg <= '0;
            rd_dev_reg    <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (ctl.item_load)
            begin
                key_hit_reg   <= 1'b0;
                char_hit_reg  <= 1'b0;
                char_byte_reg <= '0;
            end
            if (rd_en)
            begin
                rd_dev_reg <= rd_dev;
                if (!rd_raw && rd_addr == lc3_pkg::KBDR_ADDR)
                begin
                    key_hit_reg <= 1'b1;
                    kbsr_reg    <= lc3_pkg::STATUS_READY;
                end
            end
            if (st_en)
            begin
                case (st_addr)
                    lc3_pkg::KBSR_ADDR: kbsr_reg <= st_data;
                    lc3_pkg::DSR_ADDR:  dsr_reg <= st_data;
                    lc3_pkg::MCR_ADDR:  mcr_reg <= st_data;
                    lc3_pkg::DDR_ADDR:
                    begin
                        if (st_core)
                        begin
                            char_hit_reg  <= 1'b1;
                            char_byte_reg <= st_data[7:0];
                            dsr_reg       <= lc3_pkg::STATUS_READY;
                        end
                    end
                    default: ;
                endcase
            end
            if (wr_en)
                gr_reg[wr_idx] <= wr_val;
            if (wr_cc)
                cc_reg <= wr_val[15] ? lc3_pkg::CC_N
                        : (wr_val == 16'h0000) ? lc3_pkg::CC_Z : lc3_pkg::CC_P;
            if (ctl.exec && op == lc3_pkg::OP_RTI)
                fault_reg <= lc3_pkg::FAULT_PRIV;
            if (ctl.exec && op == lc3_pkg::OP_RES)
                fault_reg <= lc3_pkg::FAULT_ILLEGAL;
        end
    end

    assign stat = '{kind: item_reg.kind, op: op,
                    run: (mcr_reg != 16'h0000) && (fault_reg == lc3_pkg::FAULT_NONE)};
    assign rsp  = rsp_reg;

endmodule

FILE: design/lc3_instruction_execute_unit.sv
// Top level of the LC-3 instruction execute unit.
//
// Request channel (req_valid/req_ready/req) takes one item: a host word
// load into memory or a device register, a program counter load, or the
// execution of one instruction at the current program counter.
// Response channel (rsp_valid/rsp_ready/rsp) returns one item per request
// with the display character, key use, run state, fault code and new PC.
// Requests are taken one at a time; req_ready is high only while the
// sequencer is idle. Host loads, PC loads and instructions skipped while
// halted go from dispatch straight to the response; an instruction passes
// fetch, IR load and execute, and LD, LDR, LDI, STI and TRAP add memory or
// trap phases, as the single memory read port serves the fetch and then up
// to two dependent data reads, each a registered read. Once the response is
// loaded, the sequencer returns to idle and takes the next request.
// A finished response is held in the output register while rsp_ready is
// low; the next request is still accepted, and its own response waits
// until the held one is taken.
// Reset clears the registers, program counter, condition codes and fault,
// and sets the machine control and status words to 0x8000. Memory contents
// are not cleared and must be loaded by the host before they are read.
module lc3_instruction_execute_unit #(
    parameter int ADDR_BITS = lc3_pkg::ADDR_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lc3_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lc3_pkg::rsp_t rsp
);

    lc3_pkg::ctl_t  ctl;
    lc3_pkg::stat_t stat;

    lc3_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    lc3_datapath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctl   (ctl),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

FILE: design/lc3_checker.sv
// Port-level checks of the execute unit's response channel, bound to the top level.
`include "lc3_instruction_execute_unit_macros.svh"

module lc3_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input lc3_pkg::rsp_t rsp
);

    `LC3_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `LC3_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp))
    `LC3_ASSERT_NOW(a_fault_stops, rsp_valid && rsp.fault != lc3_pkg::FAULT_NONE, !rsp.running)
    `LC3_ASSERT_NOW(a_char_clear, rsp_valid && !rsp.char_valid, rsp.out_char == 8'h00)

endmodule

bind lc3_instruction_execute_unit lc3_checker u_lc3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
